// File: src/seq_duplicate_window_defines.svh
// Assertion macros shared by the duplicate-window checker.
`ifndef SEQ_DUPLICATE_WINDOW_DEFINES_SVH
`define SEQ_DUPLICATE_WINDOW_DEFINES_SVH

// Clocked assertion, quiet while reset is held
`define SDW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define SDW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/sdw_pkg.sv
// Shared types and constants for the sequence duplicate window.
package sdw_pkg;

  // Kind of input transaction
  typedef enum logic {
    OP_PACKET = 1'b0,
    OP_CLEAR  = 1'b1
  } sdw_op_t;

  localparam int SeqW   = 12;
  localparam int DeltaW = 13;
  localparam int CountW = 32;

  // Wrap is recognised only near the ends of the sequence space
  localparam logic [SeqW-1:0]   WRAP_LOW  = 12'h100;
  localparam logic [SeqW-1:0]   WRAP_HIGH = 12'hEFF;
  localparam logic [DeltaW-1:0] SEQ_SPAN  = 13'h1000;

  // One result transaction
  typedef struct packed {
    logic                     duplicate;
    logic signed [DeltaW-1:0] seq_delta;
    logic [CountW-1:0]        fresh_count;
  } sdw_result_t;

endpackage

// File: src/sdw_window.sv
// Delta, history mask update and fresh count for one transaction.
module sdw_window #(
  parameter int WINDOW_BITS = 32
) (
  input  sdw_pkg::sdw_op_t            operation,
  input  logic [sdw_pkg::SeqW-1:0]    seq_number,
  input  logic                        resent_flag,
  input  logic [sdw_pkg::SeqW-1:0]    newest_seq,
  input  logic [WINDOW_BITS-1:0]      history_mask,
  input  logic [sdw_pkg::CountW-1:0]  fresh_counter,
  output logic [sdw_pkg::SeqW-1:0]    newest_seq_nxt,
  output logic [WINDOW_BITS-1:0]      history_mask_nxt,
  output logic [sdw_pkg::CountW-1:0]  fresh_counter_nxt,
  output sdw_pkg::sdw_result_t        result
);
  import sdw_pkg::*;

  localparam int                IdxW   = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;
  localparam logic [DeltaW-1:0] WinLen = DeltaW'(WINDOW_BITS);

  logic [DeltaW-1:0]      cur_ext;
  logic [DeltaW-1:0]      last_ext;
  logic [DeltaW-1:0]      delta;
  logic [DeltaW-1:0]      back_dist;
  logic                   behind;
  logic                   in_window;
  logic [IdxW-1:0]        bit_idx;
  logic                   dup;
  logic [WINDOW_BITS-1:0] mask_upd;
  logic [CountW-1:0]      count_upd;

  assign cur_ext  = {1'b0, seq_number};
  assign last_ext = {1'b0, newest_seq};

  // Signed distance to the newest number, with wrap only near the ends
  always_comb begin
    if (seq_number < WRAP_LOW && newest_seq > WRAP_HIGH) begin
      delta = cur_ext + SEQ_SPAN - last_ext;
    end else if (seq_number > WRAP_HIGH && newest_seq < WRAP_LOW) begin
      delta = cur_ext - last_ext - SEQ_SPAN;
    end else begin
      delta = cur_ext - last_ext;
    end
  end

  // Zero or negative delta: test and mark a bit in the window
  assign behind    = delta[DeltaW-1] || (delta == '0);
  assign back_dist = '0 - delta;
  assign in_window = behind && (back_dist < WinLen);
  assign bit_idx   = back_dist[IdxW-1:0];
  assign dup       = in_window && history_mask[bit_idx];

  always_comb begin
    if (behind) begin
      mask_upd = in_window ? (history_mask | (WINDOW_BITS'(1) << bit_idx)) : history_mask;
    end else if (delta >= WinLen) begin
      mask_upd = WINDOW_BITS'(1);
    end else begin
      mask_upd = (history_mask << delta[IdxW-1:0]) | WINDOW_BITS'(1);
    end
  end

  // Saturating count of fresh, non-resent packets
  assign count_upd = (!dup && !resent_flag && fresh_counter != '1) ?
                     fresh_counter + CountW'(1) : fresh_counter;

  // Clear wins over everything else
  always_comb begin
    if (operation == OP_CLEAR) begin
      newest_seq_nxt     = '0;
      history_mask_nxt   = '0;
      fresh_counter_nxt  = '0;
      result.duplicate   = 1'b0;
      result.seq_delta   = '0;
      result.fresh_count = '0;
    end else begin
      newest_seq_nxt     = behind ? newest_seq : seq_number;
      history_mask_nxt   = mask_upd;
      fresh_counter_nxt  = count_upd;
      result.duplicate   = dup;
      result.seq_delta   = delta;
      result.fresh_count = count_upd;
    end
  end

endmodule

// File: src/seq_duplicate_window.sv
// out_tvalid rises in the cycle after an input transaction is accepted.
// One transaction per cycle while the output is not stalled; window state is
// updated in the accepting cycle and the result waits in a single output register.
// Reset (rst_n low, synchronous): window, newest number and count go to zero,
// output register empties.
module seq_duplicate_window #(
  parameter int WINDOW_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] seq_number, [15:12] zero
  input  logic [1:0]  in_tuser,   // [0] operation, [1] resent_flag
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [12:0] seq_delta, [44:13] fresh_count, [47:45] zero
  output logic        out_tuser   // [0] duplicate
);
  import sdw_pkg::*;

  logic [SeqW-1:0]        newest_seq_r;
  logic [SeqW-1:0]        newest_seq_nxt;
  logic [WINDOW_BITS-1:0] history_mask_r;
  logic [WINDOW_BITS-1:0] history_mask_nxt;
  logic [CountW-1:0]      fresh_counter_r;
  logic [CountW-1:0]      fresh_counter_nxt;
  logic                   out_valid_r;
  sdw_result_t            result_r;
  sdw_result_t            result_nxt;
  logic                   in_fire;

  // Take a new transaction whenever the output register is free or draining
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  sdw_window #(
    .WINDOW_BITS (WINDOW_BITS)
  ) u_sdw_window (
    .operation         (sdw_op_t'(in_tuser[0])),
    .seq_number        (in_tdata[SeqW-1:0]),
    .resent_flag       (in_tuser[1]),
    .newest_seq        (newest_seq_r),
    .history_mask      (history_mask_r),
    .fresh_counter     (fresh_counter_r),
    .newest_seq_nxt    (newest_seq_nxt),
    .history_mask_nxt  (history_mask_nxt),
    .fresh_counter_nxt (fresh_counter_nxt),
    .result            (result_nxt)
  );

  // Window state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_seq_r    <= '0;
      history_mask_r  <= '0;
      fresh_counter_r <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (in_fire) begin
        newest_seq_r    <= newest_seq_nxt;
        history_mask_r  <= history_mask_nxt;
        fresh_counter_r <= fresh_counter_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, result_r.fresh_count, result_r.seq_delta};
  assign out_tuser  = result_r.duplicate;

endmodule

// File: src/sdw_checker.sv
// Port-level checks for the sequence duplicate window, bound to the top level.
`include "seq_duplicate_window_defines.svh"

module sdw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tuser
);
  import sdw_pkg::*;

  logic clear_fire;

  // Accepted clear transaction
  assign clear_fire = in_tvalid && in_tready && (in_tuser[0] == OP_CLEAR);

  // A held result is not withdrawn
  `SDW_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")

  // Every accepted transaction shows a result in the next cycle
  `SDW_ASSERT(a_accept_result, in_tvalid && in_tready |=> out_tvalid, "no result after accept")

  // An empty output register never blocks the input
  `SDW_ASSERT(a_ready_empty, !out_tvalid |-> in_tready, "input stalled with output empty")

  // A clear transaction reports zeros
  `SDW_ASSERT(a_clear_zero, clear_fire |=> out_tdata == '0 && !out_tuser, "clear not zero")

  // Output is empty straight after reset
  `SDW_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind seq_duplicate_window sdw_checker u_sdw_checker (.*);
